// ===== rtl/core/sorted_list_insert_delete_search_unit_assert.svh =====
`ifndef SORTED_LIST_INSERT_DELETE_SEARCH_UNIT_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SLIST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted list assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SLIST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted list assertion failed");

`endif

// ===== rtl/core/slist_pkg.sv =====
`default_nettype none

package slist_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IN_WIDTH    = 32;
	localparam int OCC_W       = 5;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHF_RD,
		ST_SHF_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             hit;
		logic             full_reject;
		logic [OCC_W-1:0] occupancy;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/slist_ram.sv =====
`default_nettype none

module slist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/slist_ctrl.sv =====
`default_nettype none

`include "sorted_list_insert_delete_search_unit_assert.svh"

module slist_ctrl (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [1:0]                           kind,
	input  wire logic [slist_pkg::IN_WIDTH-1:0]       value,
	input  wire logic                                 res_free,
	output logic                                      res_valid,
	output slist_pkg::result_t                        res,
	output logic                                      ram_we,
	output logic [slist_pkg::IDX_W-1:0]               ram_waddr,
	output logic [slist_pkg::VALUE_WIDTH-1:0]         ram_wdata,
	output logic                                      ram_re,
	output logic [slist_pkg::IDX_W-1:0]               ram_raddr,
	input  wire logic [slist_pkg::VALUE_WIDTH-1:0]    ram_rdata
);

	localparam int VW = slist_pkg::VALUE_WIDTH;
	localparam int CW = slist_pkg::CNT_W;
	localparam int IW = slist_pkg::IDX_W;
	localparam int OW = slist_pkg::OCC_W;
	localparam logic [CW-1:0] CAP = CW'(slist_pkg::CAPACITY);

	slist_pkg::state_t state_q, state_d;
	logic [1:0]           kind_q;
	logic signed [VW-1:0] val_q;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [CW-1:0]        ptr_q, ptr_d;
	logic                 hit_q, hit_d;
	logic                 rej_q, rej_d;

	logic [VW+slist_pkg::IN_WIDTH-1:0] val_ext;
	logic signed [VW-1:0]              val_in;
	logic [OW+CW-1:0]                  occ_ext;
	logic                              accept;
	logic [CW-1:0]                     ptr_inc;
	logic [CW-1:0]                     ptr_dec;

	assign val_ext = {{VW{value[slist_pkg::IN_WIDTH-1]}}, value};
	assign val_in  = val_ext[VW-1:0];
	assign occ_ext = {{OW{1'b0}}, cnt_q};
	assign ptr_inc = ptr_q + 1'b1;
	assign ptr_dec = ptr_q - 1'b1;

	assign in_ready  = (state_q == slist_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == slist_pkg::ST_DONE);
	assign res.hit         = hit_q;
	assign res.full_reject = rej_q;
	assign res.occupancy   = occ_ext[OW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slist_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			val_q  <= val_in;
		end
		ptr_q <= ptr_d;
		hit_q <= hit_d;
		rej_q <= rej_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ptr_d     = ptr_q;
		hit_d     = hit_q;
		rej_d     = rej_q;
		ram_we    = 1'b0;
		ram_waddr = ptr_q[IW-1:0];
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[IW-1:0];
		case (state_q)
			slist_pkg::ST_IDLE: begin
				hit_d = 1'b0;
				rej_d = 1'b0;
				ptr_d = '0;
				if (accept) begin
					case (kind)
						slist_pkg::KIND_INSERT: begin
							if (cnt_q >= CAP) begin
								rej_d   = 1'b1;
								state_d = slist_pkg::ST_DONE;
							end else begin
								ptr_d   = cnt_q;
								state_d = slist_pkg::ST_INS_RD;
							end
						end
						slist_pkg::KIND_DELETE, slist_pkg::KIND_SEARCH: begin
							state_d = slist_pkg::ST_SCAN_RD;
						end
						default: begin
							state_d = slist_pkg::ST_DONE;
						end
					endcase
				end
			end
			slist_pkg::ST_INS_RD: begin
				if (ptr_q == '0) begin
					ram_we  = 1'b1;
					cnt_d   = cnt_q + 1'b1;
					hit_d   = 1'b1;
					state_d = slist_pkg::ST_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_dec[IW-1:0];
					state_d   = slist_pkg::ST_INS_CMP;
				end
			end
			slist_pkg::ST_INS_CMP: begin
				ram_we = 1'b1;
				if ($signed(ram_rdata) > val_q) begin
					ram_wdata = ram_rdata;
					ptr_d     = ptr_dec;
					state_d   = slist_pkg::ST_INS_RD;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					hit_d   = 1'b1;
					state_d = slist_pkg::ST_DONE;
				end
			end
			slist_pkg::ST_SCAN_RD: begin
				if (ptr_q >= cnt_q) begin
					state_d = slist_pkg::ST_DONE;
				end else begin
					ram_re  = 1'b1;
					state_d = slist_pkg::ST_SCAN_CMP;
				end
			end
			slist_pkg::ST_SCAN_CMP: begin
				if ($signed(ram_rdata) == val_q) begin
					hit_d = 1'b1;
					if (kind_q == slist_pkg::KIND_DELETE) begin
						state_d = slist_pkg::ST_SHF_RD;
					end else begin
						state_d = slist_pkg::ST_DONE;
					end
				end else begin
					ptr_d   = ptr_inc;
					state_d = slist_pkg::ST_SCAN_RD;
				end
			end
			slist_pkg::ST_SHF_RD: begin
				if (ptr_inc >= cnt_q) begin
					cnt_d   = cnt_q - 1'b1;
					state_d = slist_pkg::ST_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_inc[IW-1:0];
					state_d   = slist_pkg::ST_SHF_WR;
				end
			end
			slist_pkg::ST_SHF_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				ptr_d     = ptr_inc;
				state_d   = slist_pkg::ST_SHF_RD;
			end
			slist_pkg::ST_DONE: begin
				if (res_free) begin
					state_d = slist_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slist_pkg::ST_IDLE;
			end
		endcase
	end

	`SLIST_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CAP)
	`SLIST_ASSERT_NOW(a_rw_apart, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr)
	`SLIST_ASSERT_NOW(a_cmp_after_read, clk, arst_n,
		state_q == slist_pkg::ST_INS_CMP || state_q == slist_pkg::ST_SCAN_CMP ||
		state_q == slist_pkg::ST_SHF_WR, $past(ram_re))
	`SLIST_ASSERT_NEXT(a_done_step, clk, arst_n,
		state_q == slist_pkg::ST_DONE && res_free, cnt_q == $past(cnt_q))

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_insert_delete_search_unit.sv =====
// Sorted list of up to 16 signed 32-bit values, ascending, duplicates kept.
// Request channel: in_valid/in_ready with kind (insert, delete, search) and
// value. Result channel: out_valid/out_ready with hit, full_reject and the
// occupancy after the request.
// One request is worked on at a time; in_ready is high only while the
// sequencer is idle. The values live in a single-port-read RAM with a
// registered read port, and every step of the walk is a read followed by
// a compare or a write.
// An insert walks down from the top, moving each larger entry up one place,
// then writes the new value; a delete or a search scans up from the bottom,
// and a delete then moves the entries above the match down one place.
// A rejected insert or an unused kind code goes straight to the done state.
// The result is held in an output register; when the receiver stalls, the
// finished result waits there and the sequencer waits behind it.
// Reset clears the entry count and the control state at once; the RAM is
// not cleared, since only entries below the count are ever read.
`default_nettype none

module sorted_list_insert_delete_search_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     kind,
	input  wire logic [slist_pkg::IN_WIDTH-1:0] value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                hit,
	output logic                                full_reject,
	output logic [slist_pkg::OCC_W-1:0]         occupancy
);

	slist_pkg::result_t res;
	slist_pkg::result_t res_q;
	logic res_valid;
	logic res_free;
	logic out_valid_q;

	logic                              ram_we;
	logic [slist_pkg::IDX_W-1:0]       ram_waddr;
	logic [slist_pkg::VALUE_WIDTH-1:0] ram_wdata;
	logic                              ram_re;
	logic [slist_pkg::IDX_W-1:0]       ram_raddr;
	logic [slist_pkg::VALUE_WIDTH-1:0] ram_rdata;

	assign res_free = !out_valid_q || out_ready;

	slist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.value     (value),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	slist_ram #(
		.WIDTH (slist_pkg::VALUE_WIDTH),
		.DEPTH (slist_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = res_q.hit;
	assign full_reject = res_q.full_reject;
	assign occupancy   = res_q.occupancy;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
	import slist_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1200;
	localparam int SEGMENT_LEN = 40;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 4 * CAPACITY + 16;
	localparam int MAX_REPORTED = 10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] value;
		logic [4:0]  reps;
		logic        typed;
		result_t     res;
	} directed_row_t;

	typedef struct {
		result_t     res;
		int unsigned serial;
	} pending_t;

	// Rows with typed set carry a result that follows directly from the list contents.
	localparam directed_row_t DIRECTED_PLAN [25] = '{
		'{KIND_SEARCH, 32'h0000_0000, 5'd1, 1'b1, '{1'b0, 1'b0, 5'd0}},
		'{KIND_DELETE, 32'h8000_0000, 5'd1, 1'b1, '{1'b0, 1'b0, 5'd0}},
		'{KIND_UNUSED, 32'h0000_0000, 5'd1, 1'b1, '{1'b0, 1'b0, 5'd0}},
		'{KIND_INSERT, 32'h8000_0000, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd1}},
		'{KIND_INSERT, 32'h7fff_ffff, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd2}},
		'{KIND_INSERT, 32'hffff_ffff, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd3}},
		'{KIND_INSERT, 32'hffff_ffff, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd4}},
		'{KIND_SEARCH, 32'h8000_0000, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd4}},
		'{KIND_SEARCH, 32'h7fff_ffff, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd4}},
		'{KIND_SEARCH, 32'h0000_0001, 5'd1, 1'b1, '{1'b0, 1'b0, 5'd4}},
		'{KIND_DELETE, 32'hffff_ffff, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd3}},
		'{KIND_SEARCH, 32'hffff_ffff, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd3}},
		'{KIND_UNUSED, 32'hffff_ffff, 5'd1, 1'b1, '{1'b0, 1'b0, 5'd3}},
		'{KIND_INSERT, 32'h0000_0005, 5'd6, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{KIND_INSERT, 32'h7fff_ffff, 5'd7, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{KIND_INSERT, 32'h0000_0000, 5'd1, 1'b1, '{1'b0, 1'b1, 5'd16}},
		'{KIND_DELETE, 32'h0000_0002, 5'd1, 1'b1, '{1'b0, 1'b0, 5'd16}},
		'{KIND_SEARCH, 32'h0000_0005, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd16}},
		'{KIND_DELETE, 32'h7fff_ffff, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd15}},
		'{KIND_DELETE, 32'h8000_0000, 5'd1, 1'b1, '{1'b1, 1'b0, 5'd14}},
		'{KIND_SEARCH, 32'h8000_0000, 5'd1, 1'b1, '{1'b0, 1'b0, 5'd14}},
		'{KIND_DELETE, 32'h0000_0005, 5'd1, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{KIND_INSERT, 32'h8000_0001, 5'd1, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{KIND_INSERT, 32'h7fff_ffff, 5'd1, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{KIND_INSERT, 32'h0000_0005, 5'd1, 1'b0, '{1'b0, 1'b0, 5'd0}}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [1:0]             kind;
	logic [IN_WIDTH-1:0]    value;
	logic                   out_valid;
	logic                   out_ready;
	logic                   hit;
	logic                   full_reject;
	logic [OCC_W-1:0]       occupancy;

	int          sorted_copy[$];
	pending_t    pending_results[$];
	pending_t    oldest_pending;
	int unsigned requests_sent = 0;
	int unsigned results_checked = 0;
	int unsigned mismatch_count = 0;
	int unsigned kind_seen [4] = '{0, 0, 0, 0};
	int unsigned inserts_refused = 0;
	int unsigned deletes_missed = 0;
	int unsigned searches_found = 0;
	int unsigned times_emptied = 0;
	int unsigned peak_occupancy = 0;
	int unsigned stall_cycles;
	int          send_idle_pct = 37;
	int          recv_idle_pct = 60;

	sorted_list_insert_delete_search_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.full_reject (full_reject),
		.occupancy   (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int locate_value(input int v);
		for (int i = 0; i < sorted_copy.size(); i++) begin
			if (sorted_copy[i] == v) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic result_t update_sorted_copy(input logic [1:0] op, input logic [31:0] raw);
		result_t r;
		int      v;
		int      pos;
		v = $signed(raw);
		r = '0;
		case (op)
			KIND_INSERT: begin
				if (sorted_copy.size() >= CAPACITY) begin
					r.full_reject = 1'b1;
				end else begin
					pos = 0;
					while (pos < sorted_copy.size() && sorted_copy[pos] <= v) begin
						pos++;
					end
					sorted_copy.insert(pos, v);
					r.hit = 1'b1;
				end
			end
			KIND_DELETE: begin
				pos = locate_value(v);
				if (pos >= 0) begin
					sorted_copy.delete(pos);
					r.hit = 1'b1;
				end
			end
			KIND_SEARCH: begin
				r.hit = (locate_value(v) >= 0);
			end
			default: begin
			end
		endcase
		r.occupancy = OCC_W'(sorted_copy.size());
		return r;
	endfunction

	function automatic logic [1:0] pick_kind(input bit filling);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 3) begin
			return KIND_UNUSED;
		end else if (sel < (filling ? 63 : 23)) begin
			return KIND_INSERT;
		end else if (sel < 85) begin
			return KIND_DELETE;
		end
		return KIND_SEARCH;
	endfunction

	function automatic logic [31:0] pick_value(input logic [1:0] op);
		int sel;
		sel = $urandom_range(0, 99);
		if (sorted_copy.size() > 0 && sel < ((op == KIND_DELETE) ? 75 : 40)) begin
			return sorted_copy[$urandom_range(0, sorted_copy.size() - 1)];
		end else if (sel < 85 && sel >= 75 || sel < 55 && sel >= 40) begin
			case ($urandom_range(0, 5))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				3: return 32'hffff_ffff;
				4: return 32'h8000_0001;
				default: return 32'h7fff_fffe;
			endcase
		end else if (sel < 90) begin
			return $urandom_range(0, 15) - 8;
		end
		return $urandom;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED) begin
			$display("MISMATCH: %s", msg);
		end
	endfunction

	task automatic offer_request(input logic [1:0] req_kind, input logic [31:0] req_value,
			input logic typed, input result_t typed_res);
		pending_t entry;
		result_t  predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= req_kind;
		value <= req_value;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = update_sorted_copy(req_kind, req_value);
		entry.res = typed ? typed_res : predicted;
		entry.serial = requests_sent;
		pending_results.push_back(entry);
		requests_sent++;
		kind_seen[req_kind]++;
		if (predicted.full_reject) begin
			inserts_refused++;
		end
		if (req_kind == KIND_DELETE && !predicted.hit) begin
			deletes_missed++;
		end
		if (req_kind == KIND_SEARCH && predicted.hit) begin
			searches_found++;
		end
		if (req_kind == KIND_DELETE && predicted.hit && predicted.occupancy == 0) begin
			times_emptied++;
		end
		if (predicted.occupancy > peak_occupancy) begin
			peak_occupancy = predicted.occupancy;
		end
	endtask

	task automatic await_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("result with no request outstanding: hit=%0b full_reject=%0b occupancy=%0d",
					hit, full_reject, occupancy));
			end else begin
				oldest_pending = pending_results.pop_front();
				if (hit !== oldest_pending.res.hit || full_reject !== oldest_pending.res.full_reject
						|| occupancy !== oldest_pending.res.occupancy) begin
					note_mismatch($sformatf(
						"request %0d: expected hit=%0b full_reject=%0b occupancy=%0d, got hit=%0b full_reject=%0b occupancy=%0d",
						oldest_pending.serial, oldest_pending.res.hit, oldest_pending.res.full_reject,
						oldest_pending.res.occupancy, hit, full_reject, occupancy));
				end
				results_checked++;
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("sorted_list_insert_delete_search_unit regression: fail");
		$finish;
	end

	initial begin
		logic [1:0] op;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_INSERT;
		value = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int row = 0; row < $size(DIRECTED_PLAN); row++) begin
			repeat (DIRECTED_PLAN[row].reps) begin
				offer_request(DIRECTED_PLAN[row].kind, DIRECTED_PLAN[row].value,
					DIRECTED_PLAN[row].typed, DIRECTED_PLAN[row].res);
			end
		end
		await_all_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				op = pick_kind(((n / SEGMENT_LEN) % 2) == 0);
				offer_request(op, pick_value(op), 1'b0, '0);
			end
			await_all_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d inserts (%0d refused on a full list), %0d deletes (%0d misses), %0d searches (%0d found), %0d unused kind.",
			requests_sent, kind_seen[KIND_INSERT], inserts_refused, kind_seen[KIND_DELETE],
			deletes_missed, kind_seen[KIND_SEARCH], searches_found, kind_seen[KIND_UNUSED]);
		$display("Checked %0d results; occupancy peaked at %0d, the list was emptied %0d times; %0d mismatches.",
			results_checked, peak_occupancy, times_emptied, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("sorted_list_insert_delete_search_unit regression: pass");
		end else begin
			$display("sorted_list_insert_delete_search_unit regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/slist_pkg.sv
rtl/core/slist_ram.sv
rtl/core/slist_ctrl.sv
rtl/core/sorted_list_insert_delete_search_unit.sv
sim/testbench.sv
